/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_NOW(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* design/fla_pkg.sv */
// ---------------------------------------------------------------------------
// fla_pkg
// field widths and codes of the free-list slot allocator
// ---------------------------------------------------------------------------
package fla_pkg;

  localparam int SLOT_FW   = 10;
  localparam int STATUS_FW = 2;
  localparam int COUNT_FW  = 11;

  typedef enum logic {
    OP_BORROW  = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [STATUS_FW-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

endpackage

/* design/fla_ram.sv */
// ---------------------------------------------------------------------------
// fla_ram
// single-port-write, single-port-read ram with a registered read
// ---------------------------------------------------------------------------
module fla_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/free_list_slot_allocator_core.sv */
// ---------------------------------------------------------------------------
// free_list_slot_allocator_core
// lifo free list of slot indices; borrow pops the head, release pushes
// ---------------------------------------------------------------------------
//  channel | direction | handshake             | word
//  in      | input     | in_valid / in_ready   | operation, slot_index
//  out     | output    | out_valid / out_ready | granted_slot, status, counts
//
//  for each item, accept issues the link ram read at the head,
//  the next cycle applies the read data and loads the output register.
//  after reset the link ram is swept once over all CAPACITY entries, in_ready low.
//  a held result blocks the next accept only if out_ready stays low.
// ---------------------------------------------------------------------------
module free_list_slot_allocator_core #(
  parameter int CAPACITY = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_operation,
  input  logic [fla_pkg::SLOT_FW-1:0]     in_slot_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fla_pkg::SLOT_FW-1:0]     out_granted_slot,
  output logic [fla_pkg::STATUS_FW-1:0]   out_status,
  output logic [fla_pkg::COUNT_FW-1:0]    out_used_count,
  output logic [fla_pkg::COUNT_FW-1:0]    out_free_count
);

  import fla_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int LINK_W = $clog2(CAPACITY + 1);
  localparam logic [LINK_W-1:0] CAP_L  = LINK_W'(CAPACITY);
  localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(CAPACITY - 1);

  typedef enum logic [1:0] {S_INIT, S_IDLE, S_EXEC} state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   init_r, init_nxt;
  logic [LINK_W-1:0]   head_r, head_nxt;
  logic [LINK_W-1:0]   used_r, used_nxt;
  logic                op_r;
  logic [SLOT_FW-1:0]  idx_r;
  logic                out_valid_r, out_valid_nxt;
  logic [SLOT_FW-1:0]  out_slot_r, out_slot_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [COUNT_FW-1:0] out_used_r, out_used_nxt;
  logic [COUNT_FW-1:0] out_free_r, out_free_nxt;

  logic                in_acc;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [LINK_W-1:0]   ram_wdata;
  logic [LINK_W-1:0]   ram_rdata;
  logic [31:0]         idx_wide;
  logic [31:0]         slot_wide;
  logic [31:0]         used_wide;
  logic [31:0]         free_wide;
  logic                idx_ok;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;
  assign idx_wide = 32'(idx_r);
  assign idx_ok   = idx_wide < 32'(CAPACITY);

  fla_ram #(
    .WIDTH (LINK_W),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (head_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    init_nxt       = init_r;
    head_nxt       = head_r;
    used_nxt       = used_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = init_r;
    ram_wdata      = LINK_W'(init_r) + LINK_W'(1);
    slot_wide      = '0;
    case (state_r)
      S_INIT: begin
        // reset sweep: entry i links to i+1, the last one to null
        ram_we   = 1'b1;
        init_nxt = init_r + ADDR_W'(1);
        if (init_r == LAST_A) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        if (op_r == OP_BORROW) begin
          if (head_r == CAP_L) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            slot_wide = 32'(head_r);
            head_nxt  = ram_rdata;
            if (used_r < CAP_L) begin
              used_nxt = used_r + LINK_W'(1);
            end
          end
        end else if (!idx_ok) begin
          out_status_nxt = ST_BAD_INDEX;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = idx_wide[ADDR_W-1:0];
          ram_wdata = head_r;
          head_nxt  = idx_wide[LINK_W-1:0];
          if (used_r != '0) begin
            used_nxt = used_r - LINK_W'(1);
          end
        end
        out_slot_nxt = slot_wide[SLOT_FW-1:0];
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    used_wide    = 32'(used_nxt);
    free_wide    = 32'(CAP_L - used_nxt);
    out_used_nxt = (state_r == S_EXEC) ? used_wide[COUNT_FW-1:0] : out_used_r;
    out_free_nxt = (state_r == S_EXEC) ? free_wide[COUNT_FW-1:0] : out_free_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_r      <= '0;
      head_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      head_r      <= head_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_acc) begin
      op_r  <= in_operation;
      idx_r <= in_slot_index;
    end
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_used_r   <= out_used_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_slot_r;
  assign out_status       = out_status_r;
  assign out_used_count   = out_used_r;
  assign out_free_count   = out_free_r;

`include "assert_macros.svh"

  `ASSERT_NOW(a_no_accept_in_sweep, state_r == S_INIT, !in_ready, "accept during ram sweep")
  `ASSERT_NEXT(a_accept_to_exec, in_acc, state_r == S_EXEC, "accept did not enter exec")
  `ASSERT_NOW(a_out_free_at_exec, state_r == S_EXEC, !out_valid_r || out_ready,
              "result would overwrite a held word")
  `ASSERT_NOW(a_head_in_range, 1'b1, head_r <= CAP_L, "head beyond null")

endmodule

/* dv/free_list_slot_allocator_core_tb.sv */
// ---------------------------------------------------------------------------
// free_list_slot_allocator_core_tb
// checks borrow/release words of the slot allocator against a lifo free-list
// model kept in the bench; runs drain-to-empty, churn around empty, double
// release with count saturation and a partial return, under random backpressure
// ---------------------------------------------------------------------------
module free_list_slot_allocator_core_tb;
  import fla_pkg::*;

  localparam int POOL_SLOTS = 1024;

  typedef struct packed {
    logic [SLOT_FW-1:0]  slot;
    status_t             status;
    logic [COUNT_FW-1:0] used;
    logic [COUNT_FW-1:0] free;
  } grant_t;

  typedef struct packed {
    op_t                op;
    logic [SLOT_FW-1:0] idx;
    logic [1:0]         mode;
    logic               sync;
    grant_t             want;
  } pending_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_operation = 1'b0;
  logic [SLOT_FW-1:0]    in_slot_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SLOT_FW-1:0]    out_granted_slot;
  logic [STATUS_FW-1:0]  out_status;
  logic [COUNT_FW-1:0]   out_used_count;
  logic [COUNT_FW-1:0]   out_free_count;

  // bench copy of the free list
  logic [COUNT_FW-1:0]   link_mem [POOL_SLOTS];
  logic [COUNT_FW-1:0]   pool_head;
  logic [COUNT_FW-1:0]   alloc_cnt;

  pending_t              req_backlog[$];
  grant_t                owed_grants[$];
  int                    held_slots[$];
  int                    req_issued = 0;
  int                    accepted_cnt = 0;
  int                    mismatch_cnt = 0;
  logic [1:0]            pace_mode = 2'd0;
  logic                  sink_hold = 1'b0;

  free_list_slot_allocator_core #(
    .CAPACITY(POOL_SLOTS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_slot_index    (in_slot_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted_slot (out_granted_slot),
    .out_status       (out_status),
    .out_used_count   (out_used_count),
    .out_free_count   (out_free_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic grant_t apply_request(op_t op, logic [SLOT_FW-1:0] idx);
    grant_t g;
    g.slot   = '0;
    g.status = ST_OK;
    if (op == OP_BORROW) begin
      if (pool_head >= POOL_SLOTS) begin
        g.status = ST_EMPTY;
      end else begin
        g.slot    = pool_head[SLOT_FW-1:0];
        pool_head = link_mem[pool_head[SLOT_FW-1:0]];
        if (alloc_cnt < POOL_SLOTS) alloc_cnt = alloc_cnt + 1'b1;
      end
    end else if (idx >= POOL_SLOTS) begin
      g.status = ST_BAD_INDEX;
    end else begin
      link_mem[idx] = pool_head;
      pool_head     = COUNT_FW'(idx);
      if (alloc_cnt > 0) alloc_cnt = alloc_cnt - 1'b1;
    end
    g.used = alloc_cnt;
    g.free = COUNT_FW'(POOL_SLOTS - alloc_cnt);
    return g;
  endfunction

  task automatic queue_request(op_t op, logic [SLOT_FW-1:0] idx);
    pending_t p;
    p.op   = op;
    p.idx  = idx;
    p.mode = (req_issued < 480) ? 2'd0 : (req_issued < 960) ? 2'd1 : 2'd2;
    // hold the word back until the block has drained at each pacing change
    p.sync = (req_issued == 480 || req_issued == 960);
    p.want = apply_request(op, idx);
    if (op == OP_BORROW && p.want.status == ST_OK) held_slots.push_back(int'(p.want.slot));
    req_issued++;
    req_backlog.push_back(p);
  endtask

  task automatic queue_release(int idx);
    int j;
    for (j = 0; j < held_slots.size(); j++) begin
      if (held_slots[j] == idx) begin
        held_slots.delete(j);
        break;
      end
    end
    queue_request(OP_RELEASE, idx[SLOT_FW-1:0]);
  endtask

  task automatic note_failure(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t: %s", $time, msg);
  endtask

  // driver
  always @(posedge clk) begin : drive_proc
    logic     offer;
    pending_t nxt;
    int       gap_pct;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer = 1'b0;
      if (in_valid && in_ready) begin
        owed_grants.push_back(req_backlog[0].want);
        void'(req_backlog.pop_front());
        accepted_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (req_backlog.size() != 0) begin
          nxt     = req_backlog[0];
          gap_pct = (nxt.mode == 2'd0) ? 18 : (nxt.mode == 2'd1) ? 72 : 0;
          if (!(nxt.sync && owed_grants.size() != 0))
            offer = ($urandom_range(99, 0) >= gap_pct);
          pace_mode <= nxt.mode;
        end
        in_valid <= offer;
        if (offer) begin
          in_operation  <= nxt.op;
          in_slot_index <= nxt.idx;
        end else begin
          in_operation  <= 1'($urandom_range(1, 0));
          in_slot_index <= SLOT_FW'($urandom_range(1023, 0));
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : sink_proc
    grant_t want;
    int     stall_pct;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_grants.size() == 0) begin
          note_failure($sformatf("unexpected word slot=%0d status=%0d used=%0d free=%0d",
                                 out_granted_slot, out_status, out_used_count,
                                 out_free_count));
        end else begin
          want = owed_grants.pop_front();
          if (out_granted_slot !== want.slot || out_status !== want.status ||
              out_used_count !== want.used || out_free_count !== want.free)
            note_failure($sformatf({"exp slot=%0d status=%0d used=%0d free=%0d, ",
                                    "got slot=%0d status=%0d used=%0d free=%0d"},
                                   want.slot, want.status, want.used, want.free,
                                   out_granted_slot, out_status, out_used_count,
                                   out_free_count));
        end
      end
      stall_pct = (pace_mode == 2'd0) ? 72 : (pace_mode == 2'd1) ? 18 : 0;
      out_ready <= !sink_hold && ($urandom_range(99, 0) >= stall_pct);
    end
  end

  // long receiver stall so the block backs up into its input
  initial begin : hold_proc
    int n;
    wait (rst_n === 1'b1 && accepted_cnt >= 500);
    @(posedge clk);
    sink_hold <= 1'b1;
    for (n = 0; n < 300; n++) @(posedge clk);
    sink_hold <= 1'b0;
  end

  initial begin : limit_proc
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stim_proc
    int k;
    int x;
    for (k = 0; k < POOL_SLOTS; k++) link_mem[k] = COUNT_FW'(k + 1);
    pool_head = '0;
    alloc_cnt = '0;

    // short directed opener; borrow ignores the index field
    queue_request(OP_BORROW, 10'h3FF);
    queue_request(OP_BORROW, 10'h000);
    queue_request(OP_BORROW, 10'h155);
    queue_release(0);
    queue_release(2);
    queue_request(OP_BORROW, 10'h2AA);
    queue_request(OP_BORROW, 10'h000);
    queue_request(OP_BORROW, 10'h3FF);
    queue_release(1);
    queue_release(3);
    queue_request(OP_BORROW, 10'h2AA);
    queue_request(OP_BORROW, 10'h155);

    // drain the pool, then hit it while empty
    while (pool_head < POOL_SLOTS) begin
      if ($urandom_range(99, 0) < 97 || held_slots.size() == 0)
        queue_request(OP_BORROW, SLOT_FW'($urandom_range(1023, 0)));
      else
        queue_release(held_slots[$urandom_range(held_slots.size() - 1, 0)]);
    end
    repeat (4) queue_request(OP_BORROW, SLOT_FW'($urandom_range(1023, 0)));
    queue_release(POOL_SLOTS - 1);
    queue_request(OP_BORROW, SLOT_FW'($urandom_range(1023, 0)));

    // churn around the empty boundary
    repeat (80) begin
      if ($urandom_range(1, 0) == 0 || held_slots.size() == 0)
        queue_request(OP_BORROW, SLOT_FW'($urandom_range(1023, 0)));
      else
        queue_release(held_slots[$urandom_range(held_slots.size() - 1, 0)]);
    end
    while (pool_head < POOL_SLOTS)
      queue_request(OP_BORROW, SLOT_FW'($urandom_range(1023, 0)));
    repeat (2) queue_request(OP_BORROW, SLOT_FW'($urandom_range(1023, 0)));

    // double release links the slot to itself; borrows then saturate the count
    x = held_slots[$urandom_range(held_slots.size() - 1, 0)];
    queue_release(x);
    queue_release(x);
    repeat (6) queue_request(OP_BORROW, SLOT_FW'($urandom_range(1023, 0)));

    // hand part of the pool back
    repeat (160) begin
      if (held_slots.size() == 0)
        queue_release($urandom_range(1023, 0));
      else if ($urandom_range(99, 0) < 93)
        queue_release(held_slots[$urandom_range(held_slots.size() - 1, 0)]);
      else
        queue_request(OP_BORROW, SLOT_FW'($urandom_range(1023, 0)));
    end

    // releases of arbitrary slots
    repeat (5) queue_release($urandom_range(1023, 0));

    // noise
    repeat (60) begin
      if ($urandom_range(1, 0) == 0)
        queue_request(OP_BORROW, SLOT_FW'($urandom_range(1023, 0)));
      else
        queue_release($urandom_range(1023, 0));
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (req_backlog.size() != 0 || owed_grants.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* free_list_slot_allocator_core.f */
+incdir+design
design/fla_pkg.sv
design/fla_ram.sv
design/free_list_slot_allocator_core.sv
dv/free_list_slot_allocator_core_tb.sv
